// ===== src/mff_pkg.sv =====
package mff_pkg;

	localparam int DEF_MAX_COLS = 1024;
	localparam int DEF_MAX_ROWS = 1024;
	localparam int CFG_RESET    = 1024;
	localparam int CFG_W        = 11;
	localparam int CFG_IDX_W    = 1;
	localparam int MASK_W       = 8;
	localparam int LABEL_W      = 2;
	localparam int COUNT_W      = 4;
	localparam int NEIGHBOURS   = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS = 1'b0,
		REG_IMAGE_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_PIXEL = 1'b0,
		KIND_FLUSH = 1'b1
	} kind_t;

	typedef enum logic [LABEL_W-1:0] {
		LABEL_SOURCE = 2'd0,
		LABEL_BORDER = 2'd1,
		LABEL_INSIDE = 2'd2
	} label_t;

	// One column entry of the line store, holding two rows.
	typedef struct packed {
		logic above;
		logic centre;
	} line_bits_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

// ===== src/mask_fill_front_classifier.sv =====
// Channel | Direction | Handshake                     | Payload
// s_axis  | in        | s_axis_tvalid / s_axis_tready | tdata: mask_value, tuser: kind
// m_axis  | out       | m_axis_tvalid / m_axis_tready | tdata: label, count, centre; tlast
// cfg     | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One item is taken per clock; its result, if any, sits in the output register
// from the next cycle. The only exception is the first flush of a one-row frame,
// which steps the window twice and so holds s_axis_tready low until the second step.
// The line store read is prefetched from the next input column's address.
// Reset clears counters and the window; the line stores need no clearing pass.
// A stalled output blocks input only while the output register is full.
module mask_fill_front_classifier #(
	parameter int MAX_COLS = mff_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = mff_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mff_pkg::MASK_W-1:0]    s_axis_tdata,   // [7:0] mask_value
	input  logic [0:0]                    s_axis_tuser,   // [0] kind
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,   // [1:0] label, [5:2] neighbour_count,
	                                                      // [6] centre_masked, [7] zero
	output logic                          m_axis_tlast,   // last_pixel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mff_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mff_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CW  = $clog2(MAX_COLS);
	localparam int CSW = $clog2(MAX_COLS + 1);
	localparam int RSW = $clog2(MAX_ROWS + 1);
	localparam int IRW = $clog2(MAX_ROWS + 4);
	localparam int ROWS_RST = (mff_pkg::CFG_RESET > MAX_ROWS) ? MAX_ROWS : mff_pkg::CFG_RESET;
	localparam int COLS_RST = (mff_pkg::CFG_RESET > MAX_COLS) ? MAX_COLS : mff_pkg::CFG_RESET;

	logic [RSW-1:0] rows_q;
	logic [CSW-1:0] cols_q;
	logic [IRW-1:0] in_row_q, in_row_next;
	logic [CW-1:0]  in_col_q, in_col_next;
	logic [RSW-1:0] out_row_q, out_row_next;
	logic [CW-1:0]  out_col_q, out_col_next;
	logic           extra_q, extra_next;

	logic                 out_valid_q;
	mff_pkg::label_t      out_label_q;
	logic [mff_pkg::COUNT_W-1:0] out_count_q;
	logic                 out_centre_q;
	logic                 out_last_q;

	logic space, acc, is_flush, draining, primed, adv, new_bit, emit, restart;
	logic cfg_acc, in_col_wrap, out_col_wrap;
	logic first_col, last_col, first_row, last_row, last_px, centre;
	logic [mff_pkg::COUNT_W-1:0] count;
	mff_pkg::label_t      label;
	logic [RSW-1:0]       rows_clamped;
	logic [CSW-1:0]       cols_clamped;

	mff_pkg::line_bits_t  line_rd, line_wr;
	mff_pkg::cell_ctrl_t  cell_ctrl;
	logic [2:0]           col_new;
	logic [2:0]           win_q [3];
	logic [2:0]           win_next [3];

	mff_line_store #(.DEPTH(MAX_COLS)) u_line_store (
		.clk     (clk),
		.wr_en   (adv),
		.wr_addr (in_col_q),
		.wr_data (line_wr),
		.rd_addr (in_col_next),
		.rd_data (line_rd)
	);

	// Window columns: cell 2 takes the incoming column, older columns move down.
	mff_cell u_cell0 (.clk(clk), .arst_n(arst_n), .ctrl(cell_ctrl),
		.col_in(win_q[1]), .col_q(win_q[0]));
	mff_cell u_cell1 (.clk(clk), .arst_n(arst_n), .ctrl(cell_ctrl),
		.col_in(win_q[2]), .col_q(win_q[1]));
	mff_cell u_cell2 (.clk(clk), .arst_n(arst_n), .ctrl(cell_ctrl),
		.col_in(col_new), .col_q(win_q[2]));

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid;

	always_comb begin
		rows_clamped = RSW'(cfg_data);
		if (cfg_data == '0) begin
			rows_clamped = RSW'(1);
		end else if (32'(cfg_data) > MAX_ROWS) begin
			rows_clamped = RSW'(MAX_ROWS);
		end
		cols_clamped = CSW'(cfg_data);
		if (cfg_data == '0) begin
			cols_clamped = CSW'(1);
		end else if (32'(cfg_data) > MAX_COLS) begin
			cols_clamped = CSW'(MAX_COLS);
		end
	end

	always_comb begin
		space         = !out_valid_q || m_axis_tready;
		s_axis_tready = space && !extra_q;
		acc           = s_axis_tvalid && s_axis_tready;
		is_flush      = (mff_pkg::kind_t'(s_axis_tuser) == mff_pkg::KIND_FLUSH);
		draining      = (32'(in_row_q) >= 32'(rows_q));
		// Results start once one row plus one pixel has gone in.
		primed        = (in_row_q >= IRW'(2)) || ((in_row_q == IRW'(1)) && (in_col_q != '0));
		adv           = (acc && (is_flush == draining)) || (extra_q && space);
		new_bit       = acc && !is_flush && (s_axis_tdata != '0);
		emit          = adv && primed;

		col_new        = {new_bit, line_rd.centre, line_rd.above};
		line_wr.above  = line_rd.centre;
		line_wr.centre = new_bit;

		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = col_new;

		first_col = (out_col_q == '0);
		last_col  = (out_col_q == CW'(cols_q - 1'b1));
		first_row = (out_row_q == '0);
		last_row  = (out_row_q == RSW'(rows_q - 1'b1));
		last_px   = last_row && last_col;
		centre    = win_next[1][1];

		count = '0;
		for (int dx = 0; dx < 3; dx++) begin
			for (int dy = 0; dy < 3; dy++) begin
				if (!((dx == 1) && (dy == 1))
				    && !((dx == 0) && first_col) && !((dx == 2) && last_col)
				    && !((dy == 0) && first_row) && !((dy == 2) && last_row)) begin
					count = count + mff_pkg::COUNT_W'(win_next[dx][dy]);
				end
			end
		end

		if (count == '0) begin
			label = mff_pkg::LABEL_SOURCE;
		end else if (count < mff_pkg::COUNT_W'(mff_pkg::NEIGHBOURS)) begin
			label = centre ? mff_pkg::LABEL_BORDER : mff_pkg::LABEL_SOURCE;
		end else begin
			label = mff_pkg::LABEL_INSIDE;
		end

		restart         = cfg_acc || (emit && last_px);
		cell_ctrl.shift = adv;
		cell_ctrl.clear = restart;

		in_col_wrap  = (in_col_q == CW'(cols_q - 1'b1));
		out_col_wrap = last_col;

		in_row_next  = in_row_q;
		in_col_next  = in_col_q;
		out_row_next = out_row_q;
		out_col_next = out_col_q;
		extra_next   = extra_q;
		if (restart) begin
			in_row_next  = '0;
			in_col_next  = '0;
			out_row_next = '0;
			out_col_next = '0;
			extra_next   = 1'b0;
		end else begin
			if (adv) begin
				if (in_col_wrap) begin
					in_col_next = '0;
					in_row_next = in_row_q + 1'b1;
				end else begin
					in_col_next = in_col_q + 1'b1;
				end
			end
			if (emit) begin
				if (out_col_wrap) begin
					out_col_next = '0;
					out_row_next = out_row_q + 1'b1;
				end else begin
					out_col_next = out_col_q + 1'b1;
				end
			end
			// A flush that finds the pipeline not yet primed steps it once more.
			if (acc && is_flush && draining && !primed) begin
				extra_next = 1'b1;
			end else if (extra_q && space) begin
				extra_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= RSW'(ROWS_RST);
			cols_q    <= CSW'(COLS_RST);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			extra_q   <= 1'b0;
		end else begin
			if (cfg_acc) begin
				case (mff_pkg::cfg_reg_t'(cfg_index))
					mff_pkg::REG_IMAGE_ROWS: rows_q <= rows_clamped;
					mff_pkg::REG_IMAGE_COLS: cols_q <= cols_clamped;
					default: ;
				endcase
			end
			in_row_q  <= in_row_next;
			in_col_q  <= in_col_next;
			out_row_q <= out_row_next;
			out_col_q <= out_col_next;
			extra_q   <= extra_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_label_q  <= label;
			out_count_q  <= count;
			out_centre_q <= centre;
			out_last_q   <= last_px;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_centre_q, out_count_q, out_label_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/mff_cell.sv =====
// One column of the 3x3 window: bit 0 is the row above, bit 1 the centre
// row, bit 2 the row below.
module mff_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mff_pkg::cell_ctrl_t ctrl,
	input  logic [2:0]         col_in,
	output logic [2:0]         col_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.clear) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= col_in;
		end
	end

endmodule

// ===== src/mff_line_store.sv =====
module mff_line_store #(
	parameter int DEPTH = mff_pkg::DEF_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  mff_pkg::line_bits_t       wr_data,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output mff_pkg::line_bits_t       rd_data
);

	mff_pkg::line_bits_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the column being written this cycle returns the new entry.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data <= wr_data;
		end else begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
